>>> design/grs_pkg.sv
// Shared types and constants for the grid relaxation smoothing block.
// Used by the config registers, controller, datapath, top level and checker.
`default_nettype none

package grs_pkg;

  // Grid geometry and number formats
  localparam int MAX_EDGE    = 128;
  localparam int HEIGHT_BITS = 32;
  localparam int IDX_BITS    = $clog2(MAX_EDGE);
  localparam int ADDR_BITS   = 2 * IDX_BITS;
  localparam int EDGE_BITS   = $clog2(MAX_EDGE + 1);

  // Fixed field widths
  localparam int KIND_BITS   = 2;
  localparam int COORD_BITS  = 7;
  localparam int IN_H_BITS   = 32;
  localparam int OUT_H_BITS  = 32;
  localparam int PASS_BITS   = 8;
  localparam int RATE_BITS   = 17;
  localparam int RATE_FRAC   = 16;
  localparam int EDGE_REG_W  = 8;
  localparam logic [RATE_BITS-1:0] RATE_ONE = RATE_BITS'(1 << RATE_FRAC);

  // Stream payload widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  // Config port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_PASSES = 2'd0;
  localparam logic [1:0] REG_RATE   = 2'd1;
  localparam logic [1:0] REG_EDGE   = 2'd2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_WRITE = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    RD_HOST,
    RD_LEFT,
    RD_RIGHT,
    RD_UP,
    RD_DOWN,
    RD_CENTRE
  } rd_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_RD_L,
    ST_RD_R,
    ST_RD_U,
    ST_RD_D,
    ST_RD_C,
    ST_AVG,
    ST_MUL,
    ST_WR
  } state_t;

  // Effective configuration, clamped
  typedef struct packed {
    logic [PASS_BITS-1:0] passes;
    logic [RATE_BITS-1:0] rate;
    logic [EDGE_BITS-1:0] edge_eff;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    rd_sel_t             rd_sel;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic                acc_ld;
    logic                acc_add;
    logic                avg_ld;
    logic                mul_ld;
    logic                cell_wr;
    logic                host_wr;
    logic                out_ld;
    logic                out_from_mem;
    logic                out_status;
  } dp_cmd_t;

endpackage

`default_nettype wire

>>> design/grs_cfg_regs.sv
// APB-style configuration registers: passes, rate, edge in use.
// Depends on grs_pkg; drives clamped values to the controller and datapath.
`default_nettype none

module grs_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [grs_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [grs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [grs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output grs_pkg::cfg_t                  cfg
);
  import grs_pkg::*;

  logic [PASS_BITS-1:0]  passes_r;
  logic [RATE_BITS-1:0]  rate_r;
  logic [EDGE_REG_W-1:0] edge_r;
  logic                  wr_en;
  logic [1:0]            reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      passes_r <= '0;
      rate_r   <= '0;
      edge_r   <= EDGE_REG_W'(128);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PASSES: passes_r <= cfg_pwdata[PASS_BITS-1:0];
        REG_RATE:   rate_r   <= cfg_pwdata[RATE_BITS-1:0];
        REG_EDGE:   edge_r   <= cfg_pwdata[EDGE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PASSES: cfg_prdata = CFG_DW'(passes_r);
      REG_RATE:   cfg_prdata = CFG_DW'(rate_r);
      REG_EDGE:   cfg_prdata = CFG_DW'(edge_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.passes = passes_r;
    cfg.rate   = (rate_r > RATE_ONE) ? RATE_ONE : rate_r;
    if (32'(edge_r) > 32'(MAX_EDGE)) cfg.edge_eff = EDGE_BITS'(MAX_EDGE);
    else                             cfg.edge_eff = EDGE_BITS'(edge_r);
  end

endmodule

`default_nettype wire

>>> design/grs_ctrl.sv
// Controller: command decode, index check and the pass/row/column walk.
// Depends on grs_pkg; drives grs_datapath through dp_cmd_t.
`default_nettype none

module grs_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [grs_pkg::KIND_BITS-1:0]  in_kind,
  input  wire logic [grs_pkg::COORD_BITS-1:0] in_row,
  input  wire logic [grs_pkg::COORD_BITS-1:0] in_col,
  input  grs_pkg::cfg_t                     cfg,
  input  wire logic                         out_free,
  output grs_pkg::dp_cmd_t                  cmd
);
  import grs_pkg::*;

  state_t              state_r, state_nxt;
  logic [IDX_BITS-1:0] i_r, i_nxt;
  logic [IDX_BITS-1:0] j_r, j_nxt;
  logic [PASS_BITS-1:0] p_r, p_nxt;

  logic                 accept;
  logic                 idx_ok;
  logic [EDGE_BITS-1:0] last_idx;
  logic                 i_last, j_last, p_last;

  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign idx_ok    = (32'(in_row) < 32'(cfg.edge_eff)) && (32'(in_col) < 32'(cfg.edge_eff));
  // interior runs 1 .. edge-2
  assign last_idx  = cfg.edge_eff - EDGE_BITS'(2);
  assign i_last    = (EDGE_BITS'(i_r) == last_idx);
  assign j_last    = (EDGE_BITS'(j_r) == last_idx);
  assign p_last    = (p_r == cfg.passes - PASS_BITS'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      p_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      p_r     <= p_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    p_nxt            = p_r;
    cmd              = '0;
    cmd.rd_sel       = RD_HOST;
    cmd.row          = j_r;
    cmd.col          = i_r;

    unique case (state_r)
      ST_IDLE: begin
        cmd.row = IDX_BITS'(in_row);
        cmd.col = IDX_BITS'(in_col);
        if (accept) begin
          case (kind_t'(in_kind))
            KIND_WRITE: begin
              cmd.host_wr    = idx_ok;
              cmd.out_ld     = 1'b1;
              cmd.out_status = !idx_ok;
            end
            KIND_READ: begin
              if (idx_ok) begin
                state_nxt = ST_RD_WAIT;
              end else begin
                cmd.out_ld     = 1'b1;
                cmd.out_status = 1'b1;
              end
            end
            KIND_RUN: begin
              if (cfg.edge_eff >= EDGE_BITS'(3) && cfg.passes != '0) begin
                i_nxt     = IDX_BITS'(1);
                j_nxt     = IDX_BITS'(1);
                p_nxt     = '0;
                state_nxt = ST_RD_L;
              end else begin
                cmd.out_ld = 1'b1;
              end
            end
            default: cmd.out_ld = 1'b1;
          endcase
        end
      end
      ST_RD_WAIT: begin
        cmd.out_ld       = 1'b1;
        cmd.out_from_mem = 1'b1;
        state_nxt        = ST_IDLE;
      end
      ST_RD_L: begin
        cmd.rd_sel = RD_LEFT;
        state_nxt  = ST_RD_R;
      end
      ST_RD_R: begin
        cmd.rd_sel = RD_RIGHT;
        cmd.acc_ld = 1'b1;
        state_nxt  = ST_RD_U;
      end
      ST_RD_U: begin
        cmd.rd_sel  = RD_UP;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_RD_D;
      end
      ST_RD_D: begin
        cmd.rd_sel  = RD_DOWN;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.rd_sel  = RD_CENTRE;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_AVG;
      end
      ST_AVG: begin
        cmd.avg_ld = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_ld = 1'b1;
        state_nxt  = ST_WR;
      end
      ST_WR: begin
        cmd.cell_wr = 1'b1;
        state_nxt   = ST_RD_L;
        if (!i_last) begin
          i_nxt = i_r + IDX_BITS'(1);
        end else begin
          i_nxt = IDX_BITS'(1);
          if (!j_last) begin
            j_nxt = j_r + IDX_BITS'(1);
          end else begin
            j_nxt = IDX_BITS'(1);
            p_nxt = p_r + PASS_BITS'(1);
            if (p_last) begin
              cmd.out_ld = 1'b1;
              state_nxt  = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> design/grs_datapath.sv
// Datapath: grid memory, neighbour sum, blend multiply and result register.
// Depends on grs_pkg; sequenced by grs_ctrl through dp_cmd_t.
`default_nettype none

module grs_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  grs_pkg::dp_cmd_t                   cmd,
  input  grs_pkg::cfg_t                      cfg,
  input  wire logic signed [grs_pkg::IN_H_BITS-1:0] in_height,
  input  wire logic                          out_tready,
  output logic                               out_free,
  output logic                               out_tvalid,
  output logic        [grs_pkg::OUT_H_BITS-1:0] out_height,
  output logic                               out_status
);
  import grs_pkg::*;

  localparam int HB     = HEIGHT_BITS;
  localparam int ACC_W  = HB + 2;
  localparam int DIFF_W = HB + 1;
  localparam int PROD_W = DIFF_W + RATE_BITS + 1;
  localparam int SUM_W  = PROD_W - RATE_FRAC;
  localparam int DEPTH  = 1 << ADDR_BITS;

  // grid store, undefined until written
  logic [HB-1:0] mem [DEPTH];

  logic        [HB-1:0]      rdata_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [HB-1:0]      centre_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      out_valid_r;
  logic [OUT_H_BITS-1:0]     out_height_r;
  logic                      out_status_r;

  logic [ADDR_BITS-1:0]      raddr, waddr;
  logic [HB-1:0]             wdata;
  logic                      we;
  logic signed [HB-1:0]      rdata_s;
  logic signed [RATE_BITS:0] rate_s;
  logic signed [SUM_W-1:0]   cell_sum;
  logic signed [63:0]        rd_ext;

  function automatic logic [HB-1:0] sat_height(input logic signed [IN_H_BITS-1:0] h);
    logic signed [63:0] hx, hmax, hmin;
    hx   = 64'(h);
    hmax = (64'sd1 <<< (HB - 1)) - 64'sd1;
    hmin = -hmax - 64'sd1;
    if (hx > hmax) hx = hmax;
    if (hx < hmin) hx = hmin;
    return hx[HB-1:0];
  endfunction

  assign rdata_s = $signed(rdata_r);
  assign rate_s  = $signed({1'b0, cfg.rate});
  // centre + floor(diff * rate / 2^16)
  assign cell_sum = SUM_W'(centre_r) + $signed(prod_r[PROD_W-1:RATE_FRAC]);
  assign rd_ext   = 64'(rdata_s);

  always_comb begin
    case (cmd.rd_sel)
      RD_LEFT:  raddr = {cmd.row, cmd.col - IDX_BITS'(1)};
      RD_RIGHT: raddr = {cmd.row, cmd.col + IDX_BITS'(1)};
      RD_UP:    raddr = {cmd.row - IDX_BITS'(1), cmd.col};
      RD_DOWN:  raddr = {cmd.row + IDX_BITS'(1), cmd.col};
      default:  raddr = {cmd.row, cmd.col};
    endcase
  end

  assign waddr = {cmd.row, cmd.col};
  assign we    = cmd.host_wr || cmd.cell_wr;
  assign wdata = cmd.cell_wr ? cell_sum[HB-1:0] : sat_height(in_height);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_ld)  acc_r <= ACC_W'(rdata_s);
    if (cmd.acc_add) acc_r <= acc_r + ACC_W'(rdata_s);
    if (cmd.avg_ld) begin
      centre_r <= rdata_s;
      diff_r   <= DIFF_W'(acc_r >>> 2) - DIFF_W'(rdata_s);
    end
    if (cmd.mul_ld) prod_r <= diff_r * rate_s;
  end

  // result register; the input side is free while it is empty or its result is being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_height_r <= cmd.out_from_mem ? rd_ext[OUT_H_BITS-1:0] : '0;
      out_status_r <= cmd.out_status;
    end
  end

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_height = out_height_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

>>> design/grid_relaxation_smoothing.sv
// Top level of the grid relaxation smoothing block.
// Depends on grs_pkg, grs_cfg_regs, grs_ctrl and grs_datapath.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tuser: kind; tdata: row, column, height
//  out_    | out | out_tvalid/tready   | tuser: status; tdata: height_out
//  cfg_    | in  | psel/penable        | passes @0x0, rate @0x4, edge_in_use @0x8
//
// Writes, unused kinds, out-of-range reads and empty runs load the result register on
// acceptance, in-range reads via ST_RD_WAIT. A run with passes > 0 and edge >= 3 does per
// interior cell five reads of the single read port, an average, a multiply and a write.
// Items are accepted only in idle and while the result register is free or taken.
// Synchronous active-low reset; the grid store holds no defined value until written.
`default_nettype none

module grid_relaxation_smoothing (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [6:0] row, [13:7] column, [45:14] height, [47:46] zero
  input  wire logic [grs_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] kind
  input  wire logic [grs_pkg::KIND_BITS-1:0]     in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] height_out
  output logic      [grs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] status
  output logic                                   out_tuser,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [grs_pkg::CFG_AW-1:0]        cfg_paddr,
  input  wire logic [grs_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic      [grs_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                                   cfg_pready
);
  import grs_pkg::*;

  cfg_t                   cfg;
  dp_cmd_t                cmd;
  logic                   out_free;
  logic [COORD_BITS-1:0]  in_row, in_col;
  logic signed [IN_H_BITS-1:0] in_height;
  logic [OUT_H_BITS-1:0]  out_height;

  assign in_row    = in_tdata[6:0];
  assign in_col    = in_tdata[13:7];
  assign in_height = $signed(in_tdata[45:14]);
  assign out_tdata = OUT_TDATA_W'(out_height);

  grs_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  grs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .in_row    (in_row),
    .in_col    (in_col),
    .cfg       (cfg),
    .out_free  (out_free),
    .cmd       (cmd)
  );

  grs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .in_height  (in_height),
    .out_tready (out_tready),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_height (out_height),
    .out_status (out_tuser)
  );

endmodule

`default_nettype wire

>>> design/grs_checker.sv
// Port-level checker for grid_relaxation_smoothing, attached with bind.
// Depends on grs_pkg for the kind codes.
`default_nettype none

module grs_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [grs_pkg::KIND_BITS-1:0]   in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [grs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                            out_tuser
);
  import grs_pkg::*;

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // no new item while an untaken result blocks the output register
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("item accepted while result register full");

  // a write item answers in the next cycle
  a_write_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == KIND_WRITE) |=> out_tvalid)
    else $error("write item gave no result in the next cycle");

  // an error result carries a zero height
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == '0))
    else $error("error result with nonzero height");

endmodule

bind grid_relaxation_smoothing grs_checker u_grs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
